/* src/mcbs_pkg.sv */
// shared types and constants for the mip chain byte size block
package mcbs_pkg;

  // texture format codes
  typedef enum logic [1:0] {
    FMT_RGBA8 = 2'd0,
    FMT_BC7   = 2'd1,
    FMT_ASTC  = 2'd2,
    FMT_OTHER = 2'd3
  } fmt_t;

  // default dimension width
  localparam int DIM_BITS_DEFAULT = 16;

  // block edge of 4 pixels, 16 bytes per block, 4 bytes per pixel
  localparam int BLOCK_EDGE_SHIFT  = 2;
  localparam int BLOCK_BYTES_SHIFT = 4;
  localparam int PIXEL_BYTES_SHIFT = 2;

  localparam int BYTES_BITS = 32;
  localparam int LEVEL_COUNT_BITS = 5;

  // true for the 4x4 block compressed formats
  function automatic logic is_block(fmt_t f);
    logic r;
    case (f)
      FMT_BC7:  r = 1'b1;
      FMT_ASTC: r = 1'b1;
      default:  r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* src/mcbs_setup.sv */
// first pipeline stage: larger dimension and level count by priority encoder
module mcbs_setup #(
  parameter int DIM_BITS = mcbs_pkg::DIM_BITS_DEFAULT,
  parameter int CW = $clog2(DIM_BITS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                valid_in,
  input  mcbs_pkg::fmt_t      fmt_in,
  input  logic [DIM_BITS-1:0] w_in,
  input  logic [DIM_BITS-1:0] h_in,
  output logic                valid_out,
  output mcbs_pkg::fmt_t      fmt_out,
  output logic [DIM_BITS-1:0] w_out,
  output logic [DIM_BITS-1:0] h_out,
  output logic [CW-1:0]       count_out
);
  import mcbs_pkg::*;

  logic [DIM_BITS-1:0] big;
  logic [CW-1:0]       count_next;

  always_comb begin
    big = (w_in > h_in) ? w_in : h_in;
    count_next = '0;
    // lowest to highest so the top set bit wins
    for (int b = 0; b < DIM_BITS; b++) begin
      if (big[b]) begin
        count_next = CW'(b + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fmt_out   <= fmt_in;
      w_out     <= w_in;
      h_out     <= h_in;
      count_out <= count_next;
    end
  end

endmodule

/* src/mcbs_level.sv */
// one mip level stage: byte size of this level, accumulate the previous level
module mcbs_level #(
  parameter int DIM_BITS = mcbs_pkg::DIM_BITS_DEFAULT,
  parameter int CW = $clog2(DIM_BITS + 1),
  parameter int LEVEL = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                valid_in,
  input  mcbs_pkg::fmt_t      fmt_in,
  input  logic [DIM_BITS-1:0] w_in,
  input  logic [DIM_BITS-1:0] h_in,
  input  logic [CW-1:0]       count_in,
  input  logic [31:0]         sum_in,
  input  logic [31:0]         prod_in,
  output logic                valid_out,
  output mcbs_pkg::fmt_t      fmt_out,
  output logic [DIM_BITS-1:0] w_out,
  output logic [DIM_BITS-1:0] h_out,
  output logic [CW-1:0]       count_out,
  output logic [31:0]         sum_out,
  output logic [31:0]         prod_out
);
  import mcbs_pkg::*;

  logic [DIM_BITS-1:0]   wl, hl, ma, mb;
  logic [DIM_BITS+1:0]   wr, hr;
  logic [2*DIM_BITS-1:0] full;
  logic [63:0]           ext;
  logic                  blk;
  logic [31:0]           prod_next;

  always_comb begin
    // dimension at this level, clamped to one
    wl = w_in >> LEVEL;
    hl = h_in >> LEVEL;
    if (wl == '0) wl = DIM_BITS'(1);
    if (hl == '0) hl = DIM_BITS'(1);
    // block counts, rounded up; two spare bits keep the +3 from wrapping
    wr = ({2'b00, wl} + (DIM_BITS + 2)'(3)) >> BLOCK_EDGE_SHIFT;
    hr = ({2'b00, hl} + (DIM_BITS + 2)'(3)) >> BLOCK_EDGE_SHIFT;
    blk = is_block(fmt_in);
    ma = blk ? wr[DIM_BITS-1:0] : wl;
    mb = blk ? hr[DIM_BITS-1:0] : hl;
    full = ma * mb;
    ext = 64'(full);
    if (blk) begin
      ext = ext << BLOCK_BYTES_SHIFT;
    end else begin
      ext = ext << PIXEL_BYTES_SHIFT;
    end
    // levels beyond the chain contribute nothing
    prod_next = (count_in > CW'(LEVEL)) ? ext[31:0] : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fmt_out   <= fmt_in;
      w_out     <= w_in;
      h_out     <= h_in;
      count_out <= count_in;
      sum_out   <= sum_in + prod_in;
      prod_out  <= prod_next;
    end
  end

endmodule

/* src/mip_chain_byte_size.sv */
// top level: full mip chain byte size and level count
//
// takes one item per cycle while in_stall is low and returns one result
// item for each: one setup stage finds the larger dimension and the level
// count with a priority encoder, then one stage per possible mip level
// computes that level's size with a single multiplier while adding the
// previous level's size into the running total, and a final output
// register adds the last level. the sum wraps modulo 2^32. levels at or
// past the level count add zero, so every item takes the same path. the
// whole pipe moves together: it advances whenever the output register is
// empty or being taken, and in_stall is high exactly when it cannot
// advance. no state survives between items.
module mip_chain_byte_size #(
  parameter int DIM_BITS = mcbs_pkg::DIM_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          format,
  input  logic [DIM_BITS-1:0] base_width,
  input  logic [DIM_BITS-1:0] base_height,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         total_bytes,
  output logic [mcbs_pkg::LEVEL_COUNT_BITS-1:0] level_count
);
  import mcbs_pkg::*;

  localparam int CW = $clog2(DIM_BITS + 1);

  // pipe advance when the output slot is free or drains this cycle
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // per-stage signals, index 0 is the setup stage output
  logic                v_s     [0:DIM_BITS];
  fmt_t                fmt_s   [0:DIM_BITS];
  logic [DIM_BITS-1:0] w_s     [0:DIM_BITS];
  logic [DIM_BITS-1:0] h_s     [0:DIM_BITS];
  logic [CW-1:0]       cnt_s   [0:DIM_BITS];
  logic [31:0]         sum_s   [0:DIM_BITS];
  logic [31:0]         prod_s  [0:DIM_BITS];

  mcbs_setup #(
    .DIM_BITS (DIM_BITS),
    .CW       (CW)
  ) u_setup (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .valid_in  (in_valid),
    .fmt_in    (fmt_t'(format)),
    .w_in      (base_width),
    .h_in      (base_height),
    .valid_out (v_s[0]),
    .fmt_out   (fmt_s[0]),
    .w_out     (w_s[0]),
    .h_out     (h_s[0]),
    .count_out (cnt_s[0])
  );

  // the running total and pending product start at zero
  assign sum_s[0]  = 32'd0;
  assign prod_s[0] = 32'd0;

  // one stage per mip level
  for (genvar l = 0; l < DIM_BITS; l++) begin : g_level
    mcbs_level #(
      .DIM_BITS (DIM_BITS),
      .CW       (CW),
      .LEVEL    (l)
    ) u_level (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .valid_in  (v_s[l]),
      .fmt_in    (fmt_s[l]),
      .w_in      (w_s[l]),
      .h_in      (h_s[l]),
      .count_in  (cnt_s[l]),
      .sum_in    (sum_s[l]),
      .prod_in   (prod_s[l]),
      .valid_out (v_s[l+1]),
      .fmt_out   (fmt_s[l+1]),
      .w_out     (w_s[l+1]),
      .h_out     (h_s[l+1]),
      .count_out (cnt_s[l+1]),
      .sum_out   (sum_s[l+1]),
      .prod_out  (prod_s[l+1])
    );
  end

  // output register: fold in the last level, count masked to its port width
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v_s[DIM_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      total_bytes <= sum_s[DIM_BITS] + prod_s[DIM_BITS];
      level_count <= LEVEL_COUNT_BITS'(cnt_s[DIM_BITS]);
    end
  end

endmodule
